>>> rtl/core/olq_pkg.sv
// ----------------------------------------------------------------------------
// olq_pkg: shared definitions for the ordered list deque
// Entry layout, operation codes, status codes and the default capacity.
// ----------------------------------------------------------------------------
package olq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int MODE_W = 3;
  localparam int STAT_W = 2;
  localparam int POS_W  = 5;
  localparam int HDL_W  = 16;

  // Operation codes carried on the mode port.
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [HDL_W-1:0] id;
    logic [HDL_W-1:0] name;
    logic [HDL_W-1:0] kind;
  } entry_t;

endpackage

>>> rtl/core/ordered_list_deque_with_insert.sv
// ----------------------------------------------------------------------------
// ordered_list_deque_with_insert: bounded ordered list with deque operations
// Push front/back, positional insert and pop front/back over a one-read,
// one-write entry memory; entries are moved one slot at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: a full add, an empty pop or an unused mode returns done in the cycle
//   after the start transaction. An add reads and writes each moved entry, then
//   writes the new one into the gap; pop reads then captures, and pop front shifts.
// Throughput: one transaction at a time; busy stays high while entries move,
//   one read and one write per move. The receiver cannot stall.
// Reset: rst empties the list; memory contents are not cleared.
module ordered_list_deque_with_insert #(
  parameter int CAPACITY = olq_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  // command side
  input  logic                        start,
  output logic                        busy,
  input  logic [olq_pkg::MODE_W-1:0]  mode,
  input  logic [olq_pkg::HDL_W-1:0]   entry_id,
  input  logic [olq_pkg::HDL_W-1:0]   name_handle,
  input  logic [olq_pkg::HDL_W-1:0]   kind_handle,
  input  logic [olq_pkg::POS_W-1:0]   position,
  // result side
  output logic                        done,
  output logic [olq_pkg::STAT_W-1:0]  status,
  output logic                        removed_valid,
  output logic [olq_pkg::HDL_W-1:0]   removed_id,
  output logic [olq_pkg::HDL_W-1:0]   removed_name,
  output logic [olq_pkg::HDL_W-1:0]   removed_kind,
  output logic [CNT_W-1:0]            occupancy
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Width wide enough to compare the insert position against the count.
  localparam int CMP_W  = (CNT_W > olq_pkg::POS_W) ? CNT_W : olq_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,   // read the entry below the slot being opened
    S_INS_WR,   // write it one slot toward the back
    S_INS_PUT,  // drop the new entry into the gap
    S_POP_RD,   // read the entry being removed
    S_POP_CAP,  // capture it
    S_SHF_RD,   // read the next entry behind the gap
    S_SHF_WR    // write it one slot toward the front
  } state_t;

  state_t          state;
  logic [CNT_W-1:0] count;      // entries held
  logic [CNT_W-1:0] idx;        // slot currently being moved
  logic [CNT_W-1:0] at;         // insert target slot
  logic             pop_front;  // popping at the front, so close the gap
  olq_pkg::entry_t  new_entry;  // entry held while the gap opens

  // Memory port controls driven by the sequencer.
  logic             we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  olq_pkg::entry_t  wdata;
  olq_pkg::entry_t  rdata;

  // Shared address unit: step the move index up or down by one.
  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] count_dec;
  logic [CNT_W-1:0] at_calc;
  logic             is_add;
  logic             is_pop;

  assign idx_dec   = idx - 1'b1;
  assign idx_inc   = idx + 1'b1;
  assign count_dec = count - 1'b1;

  assign is_add = (mode == olq_pkg::MODE_PUSH_FRONT) || (mode == olq_pkg::MODE_PUSH_BACK) ||
                  (mode == olq_pkg::MODE_INSERT);
  assign is_pop = (mode == olq_pkg::MODE_POP_FRONT) || (mode == olq_pkg::MODE_POP_BACK);

  // Target slot for an add: front, back, or the position clamped to the count.
  always_comb begin
    unique case (mode)
      olq_pkg::MODE_PUSH_FRONT: at_calc = '0;
      olq_pkg::MODE_PUSH_BACK:  at_calc = count;
      olq_pkg::MODE_INSERT: begin
        if (CMP_W'(position) > CMP_W'(count)) begin
          at_calc = count;
        end else begin
          at_calc = CNT_W'(position);
        end
      end
      default:                  at_calc = count;
    endcase
  end

  // Memory port selection per sequencer state.
  always_comb begin
    we    = 1'b0;
    waddr = idx[ADDR_W-1:0];
    wdata = rdata;
    raddr = idx[ADDR_W-1:0];
    unique case (state)
      S_INS_RD: raddr = idx_dec[ADDR_W-1:0];
      S_INS_WR: we    = 1'b1;
      S_INS_PUT: begin
        we    = 1'b1;
        waddr = at[ADDR_W-1:0];
        wdata = new_entry;
      end
      S_SHF_RD: raddr = idx_inc[ADDR_W-1:0];
      S_SHF_WR: we    = 1'b1;
      default: ;
    endcase
  end

  olq_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer: state, counters and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      idx           <= '0;
      at            <= '0;
      pop_front     <= 1'b0;
      busy          <= 1'b0;
      done          <= 1'b0;
      status        <= olq_pkg::STAT_OK;
      removed_valid <= 1'b0;
      removed_id    <= '0;
      removed_name  <= '0;
      removed_kind  <= '0;
      occupancy     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            new_entry.id   <= entry_id;
            new_entry.name <= name_handle;
            new_entry.kind <= kind_handle;
            pop_front      <= (mode == olq_pkg::MODE_POP_FRONT);
            at             <= at_calc;
            if (is_add && count != CAP_CNT) begin
              // Open a gap at the target, moving entries from the back.
              idx   <= count;
              busy  <= 1'b1;
              state <= (count > at_calc) ? S_INS_RD : S_INS_PUT;
            end else if (is_pop && count != '0) begin
              idx   <= (mode == olq_pkg::MODE_POP_FRONT) ? '0 : count_dec;
              busy  <= 1'b1;
              state <= S_POP_RD;
            end else begin
              // Full add, empty pop or unused mode: answer at once.
              done          <= 1'b1;
              status        <= is_add ? olq_pkg::STAT_FULL :
                               (is_pop ? olq_pkg::STAT_EMPTY : olq_pkg::STAT_OK);
              removed_valid <= 1'b0;
              removed_id    <= '0;
              removed_name  <= '0;
              removed_kind  <= '0;
              occupancy     <= count;
            end
          end
        end
        S_INS_RD: begin
          state <= S_INS_WR;
        end
        S_INS_WR: begin
          idx   <= idx_dec;
          state <= (idx_dec == at) ? S_INS_PUT : S_INS_RD;
        end
        S_INS_PUT: begin
          count         <= count + 1'b1;
          busy          <= 1'b0;
          done          <= 1'b1;
          status        <= olq_pkg::STAT_OK;
          removed_valid <= 1'b0;
          removed_id    <= '0;
          removed_name  <= '0;
          removed_kind  <= '0;
          occupancy     <= count + 1'b1;
          state         <= S_IDLE;
        end
        S_POP_RD: begin
          state <= S_POP_CAP;
        end
        S_POP_CAP: begin
          removed_id    <= rdata.id;
          removed_name  <= rdata.name;
          removed_kind  <= rdata.kind;
          removed_valid <= 1'b1;
          status        <= olq_pkg::STAT_OK;
          if (pop_front && count_dec != '0) begin
            // Close the gap at the front, moving entries forward.
            state <= S_SHF_RD;
          end else begin
            count     <= count_dec;
            occupancy <= count_dec;
            busy      <= 1'b0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_SHF_RD: begin
          state <= S_SHF_WR;
        end
        S_SHF_WR: begin
          idx <= idx_inc;
          if (idx_inc == count_dec) begin
            count     <= count_dec;
            occupancy <= count_dec;
            busy      <= 1'b0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_SHF_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/olq_ram.sv
// ----------------------------------------------------------------------------
// olq_ram: entry storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module olq_ram #(
  parameter int DEPTH  = olq_pkg::CAPACITY_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  olq_pkg::entry_t       wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output olq_pkg::entry_t       rdata
);

  olq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/ordered_list_deque_with_insert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_deque_with_insert_test: self-checking bench for the list deque
// Drives push, insert and pop commands through the start/busy handshake,
// mirrors the list contents in a small class and checks every done strobe
// against the mirror, field by field, in order of issue.
// ----------------------------------------------------------------------------
module ordered_list_deque_with_insert_test;

  localparam int DEPTH       = olq_pkg::CAPACITY_DEF;
  localparam int MODE_W      = olq_pkg::MODE_W;
  localparam int STAT_W      = olq_pkg::STAT_W;
  localparam int POS_W       = olq_pkg::POS_W;
  localparam int HDL_W       = olq_pkg::HDL_W;
  localparam int OCC_W       = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYC  = 2 * DEPTH + 8;

  // Mode codes the block treats as a no-op.
  localparam logic [MODE_W-1:0] MODE_NONE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_NONE_LAST  = 3'd7;

  // One result as the block reports it.
  typedef struct {
    logic [STAT_W-1:0] status;
    logic              valid;
    logic [HDL_W-1:0]  id;
    logic [HDL_W-1:0]  name;
    logic [HDL_W-1:0]  kind;
    logic [OCC_W-1:0]  occ;
  } outcome_t;

  // Mirror of the list: applies each accepted command to its own copy of the
  // entries and queues the outcome the block must report for it.
  class deque_mirror;
    olq_pkg::entry_t entries[$];
    outcome_t        awaited[$];
    int              faults;

    function int pending();
      return awaited.size();
    endfunction

    function void record_command(logic [MODE_W-1:0] op, logic [HDL_W-1:0] id,
                                 logic [HDL_W-1:0] nm, logic [HDL_W-1:0] kd,
                                 logic [POS_W-1:0] pos);
      outcome_t        r;
      olq_pkg::entry_t e;
      int              at;
      r = '{default: '0};
      e = '{id: id, name: nm, kind: kd};
      case (op) inside
        olq_pkg::MODE_PUSH_FRONT, olq_pkg::MODE_PUSH_BACK, olq_pkg::MODE_INSERT: begin
          if (entries.size() >= DEPTH) begin
            r.status = olq_pkg::STAT_FULL;
          end else begin
            if (op == olq_pkg::MODE_PUSH_FRONT) at = 0;
            else if (op == olq_pkg::MODE_PUSH_BACK) at = entries.size();
            else at = (int'(pos) > entries.size()) ? entries.size() : int'(pos);
            entries.insert(at, e);
          end
        end
        olq_pkg::MODE_POP_FRONT, olq_pkg::MODE_POP_BACK: begin
          if (entries.size() == 0) begin
            r.status = olq_pkg::STAT_EMPTY;
          end else begin
            at = (op == olq_pkg::MODE_POP_FRONT) ? 0 : entries.size() - 1;
            r.valid = 1'b1;
            r.id    = entries[at].id;
            r.name  = entries[at].name;
            r.kind  = entries[at].kind;
            entries.delete(at);
          end
        end
        default: ;
      endcase
      r.status = (r.status === 'x) ? olq_pkg::STAT_OK : r.status;
      r.occ    = OCC_W'(entries.size());
      awaited.push_back(r);
    endfunction

    function void compare_field(string label, logic [HDL_W-1:0] want,
                                logic [HDL_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
        faults++;
      end
    endfunction

    function void match_result(outcome_t got);
      outcome_t want;
      if (awaited.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        faults++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", HDL_W'(want.status), HDL_W'(got.status));
      compare_field("removed_valid", HDL_W'(want.valid), HDL_W'(got.valid));
      compare_field("removed_id", want.id, got.id);
      compare_field("removed_name", want.name, got.name);
      compare_field("removed_kind", want.kind, got.kind);
      compare_field("occupancy", HDL_W'(want.occ), HDL_W'(got.occ));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] mode;
  logic [HDL_W-1:0]  entry_id;
  logic [HDL_W-1:0]  name_handle;
  logic [HDL_W-1:0]  kind_handle;
  logic [POS_W-1:0]  position;
  logic              done;
  logic [STAT_W-1:0] status;
  logic              removed_valid;
  logic [HDL_W-1:0]  removed_id;
  logic [HDL_W-1:0]  removed_name;
  logic [HDL_W-1:0]  removed_kind;
  logic [OCC_W-1:0]  occupancy;

  deque_mirror mirror = new();
  int          quiet_cycles = 0;
  bit          idle_gaps = 1'b1;

  ordered_list_deque_with_insert dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .entry_id     (entry_id),
    .name_handle  (name_handle),
    .kind_handle  (kind_handle),
    .position     (position),
    .done         (done),
    .status       (status),
    .removed_valid(removed_valid),
    .removed_id   (removed_id),
    .removed_name (removed_name),
    .removed_kind (removed_kind),
    .occupancy    (occupancy)
  );

  always #10 clk = ~clk;

  // Monitor: everything read here is the value held up to this edge, so the
  // driver's nonblocking updates at the same edge cannot leak in. Check the
  // strobed result first, then fold the command accepted at this edge into
  // the mirror. A done can never belong to the command accepted at the same
  // edge, since done is registered and rises in the next cycle at the earliest.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        mirror.match_result('{status: status, valid: removed_valid, id: removed_id,
                              name: removed_name, kind: removed_kind, occ: occupancy});
      end
      if (start && !busy) begin
        mirror.record_command(mode, entry_id, name_handle, kind_handle, position);
      end
      // Watchdog: count edges where neither side moves a transaction.
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** ordered_list_deque_with_insert: FAILED **");
        $finish;
      end
    end
  end

  // Gap before the next command: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one command and hold it until the block takes it. With no gap the
  // next call raises start again in this same step, so start stays high and
  // is never lowered and raised within one step.
  task automatic send(input logic [MODE_W-1:0] op, input logic [HDL_W-1:0] id,
                      input logic [HDL_W-1:0] nm, input logic [HDL_W-1:0] kd,
                      input logic [POS_W-1:0] pos);
    int gap;
    mode        <= op;
    entry_id    <= id;
    name_handle <= nm;
    kind_handle <= kd;
    position    <= pos;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    gap = idle_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every outstanding result has come back.
  // Wait for an edge first so the monitor has recorded the last command.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  // One random command. add_pct steers the fill level: high values push the
  // list toward full, low values drain it. Positions mostly fall inside the
  // list's range, with some past the end to exercise clamping.
  task automatic send_random(input int add_pct);
    int                roll;
    logic [MODE_W-1:0] op;
    logic [POS_W-1:0]  pos;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      op = MODE_W'($urandom_range(olq_pkg::MODE_PUSH_FRONT, olq_pkg::MODE_INSERT));
    end else if (roll < 97) begin
      op = MODE_W'($urandom_range(olq_pkg::MODE_POP_FRONT, olq_pkg::MODE_POP_BACK));
    end else begin
      op = MODE_W'($urandom_range(MODE_NONE_FIRST, MODE_NONE_LAST));
    end
    if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(DEPTH + 1, 31));
    else pos = POS_W'($urandom_range(0, DEPTH));
    send(op, HDL_W'($urandom()), HDL_W'($urandom()), HDL_W'($urandom()), pos);
  endtask

  int mix[8] = '{75, 25, 55, 90, 10, 50, 65, 35};

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    mode        <= olq_pkg::MODE_PUSH_FRONT;
    entry_id    <= '0;
    name_handle <= '0;
    kind_handle <= '0;
    position    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: pops on the empty list, then the no-op modes with every field
    // bit set.
    send(olq_pkg::MODE_POP_FRONT, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send(olq_pkg::MODE_POP_BACK, 16'hffff, 16'hffff, 16'hffff, 5'd31);
    for (int m = MODE_NONE_FIRST; m <= MODE_NONE_LAST; m++) begin
      send(MODE_W'(m), 16'hffff, 16'hffff, 16'hffff, 5'd31);
    end

    // Insert into the empty list lands at the front whatever the position.
    send(olq_pkg::MODE_INSERT, 16'h1234, 16'h5678, 16'h9abc, 5'd9);
    send(olq_pkg::MODE_PUSH_FRONT, 16'hffff, 16'hffff, 16'hffff, 5'd0);
    send(olq_pkg::MODE_PUSH_BACK, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    // Position zero goes to the front; a position past the end appends.
    send(olq_pkg::MODE_INSERT, 16'h0001, 16'h0002, 16'h0003, 5'd0);
    send(olq_pkg::MODE_INSERT, 16'h8000, 16'h4000, 16'h2000, 5'd31);
    send(olq_pkg::MODE_INSERT, 16'haaaa, 16'h5555, 16'hc3c3, 5'd2);

    // Six held now: fill the remaining slots with a mix of add modes.
    for (int i = 0; i < DEPTH - 6; i++) begin
      send(MODE_W'(i % 3), HDL_W'($urandom()), HDL_W'($urandom()), HDL_W'($urandom()),
           POS_W'($urandom_range(0, DEPTH)));
    end
    // Each add mode on the full list must be rejected.
    send(olq_pkg::MODE_PUSH_FRONT, 16'hdead, 16'hbeef, 16'hf00d, 5'd0);
    send(olq_pkg::MODE_PUSH_BACK, 16'hdead, 16'hbeef, 16'hf00d, 5'd0);
    send(olq_pkg::MODE_INSERT, 16'hdead, 16'hbeef, 16'hf00d, 5'd4);
    send(olq_pkg::MODE_POP_FRONT, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send(olq_pkg::MODE_POP_BACK, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    settle();

    // Random phases, each with its own fill bias; some run back to back with
    // no idling. Let the block drain completely between phases.
    for (int ph = 0; ph < 8; ph++) begin
      idle_gaps = (ph % 3 != 1);
      for (int n = 0; n < 100; n++) send_random(mix[ph]);
      settle();
    end

    // Allow time for any stray strobe to show up before judging.
    repeat (SETTLE_CYC) @(posedge clk);
    if (mirror.faults == 0 && mirror.pending() == 0) begin
      $display("** ordered_list_deque_with_insert: PASSED **");
    end else begin
      $display("** ordered_list_deque_with_insert: FAILED **");
    end
    $finish;
  end

endmodule
